### rtl/ldr_sb_pkg.sv
// ldr_sb_pkg: shared types and constants of the light-sensor shadow detector
// covers request/response payloads, memory entry layout and command codes
// no dependencies
package ldr_sb_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 16;
  localparam int BASE_W        = SAMPLE_BITS + FRACTION_BITS;
  localparam int WEIGHT_W      = 16;
  localparam int CFG_W         = 16;
  localparam int CHAN_W        = 2;
  localparam int BRIGHT_W      = 8;
  localparam int NUM_W         = SAMPLE_BITS + BRIGHT_W;
  localparam int PROD_W        = SAMPLE_BITS + FRACTION_BITS + 1;

  // weight of exactly one in Q1.FRACTION_BITS
  localparam logic [FRACTION_BITS:0] WEIGHT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic {
    CMD_CALIBRATE = 1'b0,
    CMD_MEASURE   = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_FAST_WEIGHT = 1'b0,
    REG_SLOW_WEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                   command;
    logic [CHAN_W-1:0]      channel;
    logic [SAMPLE_BITS-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   out_channel;
    logic [BRIGHT_W-1:0] brightness;
  } rsp_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] reference_level;
    logic [BASE_W-1:0]      tracked_baseline;
  } entry_t;

endpackage

### rtl/ldr_sb_mem.sv
// ldr_sb_mem: per-channel state memory, one write and one registered read port
// entries read as zero until first written; uses ldr_sb_pkg
module ldr_sb_mem #(
  parameter int DEPTH = 3,
  parameter int AW    = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ldr_sb_pkg::entry_t  wr_data,
  input  logic [AW-1:0]       rd_addr,
  output ldr_sb_pkg::entry_t  rd_data
);
  import ldr_sb_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld;
  entry_t           rd_q;
  logic             rd_vld;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // written marks, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

### rtl/ldr_sb_div.sv
// ldr_sb_div: restoring divider, one quotient bit per cycle, eight steps
// quotient must fit in BRIGHT_W bits; uses ldr_sb_pkg
module ldr_sb_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ldr_sb_pkg::NUM_W-1:0]        num,
  input  logic [ldr_sb_pkg::SAMPLE_BITS-1:0]  den,
  output logic                                done,
  output logic [ldr_sb_pkg::BRIGHT_W-1:0]     quot
);
  import ldr_sb_pkg::*;

  localparam int CW = $clog2(BRIGHT_W);

  logic [NUM_W-1:0]       rem;
  logic [SAMPLE_BITS-1:0] den_q;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic [NUM_W-1:0]       trial;

  // shifted divisor for the current quotient bit
  assign trial = NUM_W'(den_q) << cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one compare and subtract per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
      cnt   <= CW'(BRIGHT_W - 1);
      quot  <= '0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem       <= rem - trial;
        quot[cnt] <= 1'b1;
      end
      cnt <= cnt - 1'b1;
    end
  end

endmodule

### rtl/ldr_shadow_brightness.sv
// Light-sensor shadow detector. A calibrate request stores the sample as the
// channel's reference and tracked baseline and gives no response. A measure
// request reads the channel entry from a small synchronous memory, blends
// reference and sample with the fast or slow weight through one shared
// multiplier (states S_MULA, S_MULB), writes the new baseline back and divides
// the shadow depth in an eight-step serial divider before it gives its response.
// Requests for a channel at or above CHANNELS are taken and dropped. The
// response waits in its own register, so the next request is taken while it
// is pending.
// depends on ldr_sb_pkg, ldr_sb_mem, ldr_sb_div
module ldr_shadow_brightness #(
  parameter int CHANNELS = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  ldr_sb_pkg::req_t               req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output ldr_sb_pkg::rsp_t               rsp,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [ldr_sb_pkg::CFG_W-1:0]   cfg_data
);
  import ldr_sb_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MULA = 7'b0000100,
    S_MULB = 7'b0001000,
    S_WB   = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [WEIGHT_W-1:0]      fast_w, slow_w;
  logic [4:0]               ch_ext;
  logic                     in_range;
  logic [AW-1:0]            in_addr;
  logic                     accept;

  logic [CHAN_W-1:0]        ch_q;
  logic [AW-1:0]            addr_q;
  logic [SAMPLE_BITS-1:0]   smp_q;
  logic [SAMPLE_BITS-1:0]   ref_q;
  logic [FRACTION_BITS:0]   wgt_q;
  logic [BASE_W-1:0]        acc_q;
  logic [BASE_W-1:0]        base_q;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  entry_t                   wr_data;
  entry_t                   rd_data;

  logic [FRACTION_BITS:0]   fast_c, slow_c, inv_w;
  logic [SAMPLE_BITS-1:0]   mul_x;
  logic [FRACTION_BITS:0]   mul_y;
  logic [PROD_W-1:0]        mul_p;

  logic [SAMPLE_BITS-1:0]   whole, delta, den;
  logic                     pos;
  logic [NUM_W-1:0]         num;
  logic                     div_start, div_done;
  logic [BRIGHT_W-1:0]      quot;
  logic                     rsp_load;

  // weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_w <= WEIGHT_W'(45875);
      slow_w <= WEIGHT_W'(66);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FAST_WEIGHT: fast_w <= cfg_data;
        REG_SLOW_WEIGHT: slow_w <= cfg_data;
        default: ;
      endcase
    end
  end

  // request decode
  assign ch_ext    = 5'(req.channel);
  assign in_range  = ch_ext < 5'(CHANNELS);
  assign in_addr   = ch_ext[AW-1:0];
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // weights above one count as one
  assign fast_c = ((FRACTION_BITS+1)'(fast_w) > WEIGHT_ONE) ? WEIGHT_ONE
                                                              : (FRACTION_BITS+1)'(fast_w);
  assign slow_c = ((FRACTION_BITS+1)'(slow_w) > WEIGHT_ONE) ? WEIGHT_ONE
                                                              : (FRACTION_BITS+1)'(slow_w);
  assign inv_w  = WEIGHT_ONE - wgt_q;

  // shared multiplier: reference part first, then sample part
  assign mul_x = (state == S_MULA) ? ref_q : smp_q;
  assign mul_y = (state == S_MULA) ? inv_w : wgt_q;
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  // brightness numerator and divisor from the new baseline
  assign whole = base_q[BASE_W-1:FRACTION_BITS];
  assign pos   = whole >= smp_q;
  assign delta = whole - smp_q;
  assign num   = pos ? (NUM_W'({delta, {BRIGHT_W{1'b0}}}) - NUM_W'(delta)) : '0;
  assign den   = (whole == '0) ? SAMPLE_BITS'(1) : whole;

  // memory write: calibrate at acceptance, measure at write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_addr;
    wr_data = '0;
    if (state == S_WB) begin
      wr_en   = 1'b1;
      wr_addr = addr_q;
      wr_data.reference_level  = ref_q;
      wr_data.tracked_baseline = base_q;
    end else if (accept && in_range && req.command == CMD_CALIBRATE) begin
      wr_en = 1'b1;
      wr_data.reference_level  = req.sample;
      wr_data.tracked_baseline = {req.sample, {FRACTION_BITS{1'b0}}};
    end
  end

  ldr_sb_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  assign div_start = (state == S_WB);

  ldr_sb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_range && req.command == CMD_MEASURE) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_MULA;
      S_MULA: state_next = S_MULB;
      S_MULB: state_next = S_WB;
      S_WB:   state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q   <= req.channel;
      addr_q <= in_addr;
      smp_q  <= req.sample;
    end
    if (state == S_READ) begin
      ref_q <= rd_data.reference_level;
      wgt_q <= ({smp_q, {FRACTION_BITS{1'b0}}} > rd_data.tracked_baseline) ? fast_c
                                                                            : slow_c;
    end
    if (state == S_MULA) begin
      acc_q <= mul_p[BASE_W-1:0];
    end
    if (state == S_MULB) begin
      base_q <= acc_q + mul_p[BASE_W-1:0];
    end
  end

  // response register
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.out_channel <= ch_q;
      rsp.brightness  <= quot;
    end
  end

endmodule

### rtl/ldr_sb_checker.sv
// ldr_sb_checker: port-level checks of the shadow detector, bound to the top
// uses ldr_sb_pkg; attaches to ldr_shadow_brightness
module ldr_sb_checker #(
  parameter int CHANNELS = 3
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input ldr_sb_pkg::req_t              req,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input ldr_sb_pkg::rsp_t              rsp
);
  import ldr_sb_pkg::*;

  logic req_take;
  logic meas_take;

  assign req_take  = req_valid && !req_stall;
  assign meas_take = req_take && req.command == CMD_MEASURE
                     && (5'(req.channel) < 5'(CHANNELS));

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // responses only for channels that exist
  a_rsp_chan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 5'(rsp.out_channel) < 5'(CHANNELS))
    else $error("response for a channel out of range");

  // a measure request occupies the block
  a_meas_busy: assert property (@(posedge clk) disable iff (rst)
    meas_take |=> req_stall)
    else $error("request taken right after a measure request");

  // a new response comes only at the end of a busy period
  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a measure in progress");

  // calibrate on an idle block gives nothing
  a_cal_silent: assert property (@(posedge clk) disable iff (rst)
    req_take && req.command == CMD_CALIBRATE && !rsp_valid |=> !rsp_valid)
    else $error("response after a calibrate request");

endmodule

bind ldr_shadow_brightness ldr_sb_checker #(.CHANNELS(CHANNELS)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
